// File: rtl/i2c_master_write_read_sequencer_unit_macros.svh
// ---------------------------------------------------------------------------
// I2C write/read sequencer assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_READ_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_WRITE_READ_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define I2CMWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define I2CMWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CMWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define I2CMWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/i2cmws_pkg.sv
// ---------------------------------------------------------------------------
// I2C write/read sequencer package
// Item types, item kind codes and bus command codes.
// ---------------------------------------------------------------------------
package i2cmws_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_EVENT  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Bus commands
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_RESTART   = 3'd3;
  localparam logic [2:0] CMD_ACK_RECV  = 3'd4;
  localparam logic [2:0] CMD_NACK_STOP = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  slave_address;
    logic [4:0]  write_count;
    logic [15:0] read_count;
    logic        with_read;
    logic        nack_received;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] bus_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       error;
  } out_item_t;

endpackage

// File: rtl/i2cmws_seq.sv
// ---------------------------------------------------------------------------
// I2C write/read sequencer decision core
// Holds the transaction state and write buffer, decides one command per item.
// ---------------------------------------------------------------------------
`include "i2c_master_write_read_sequencer_unit_macros.svh"

module i2cmws_seq #(
  parameter int WRITE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  i2cmws_pkg::in_item_t item,
  output i2cmws_pkg::out_item_t result
);

  localparam int CW = $clog2(WRITE_DEPTH + 1);
  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int WW = (CW > 5) ? CW : 5;

  logic [7:0]    wbuf [WRITE_DEPTH];
  logic [7:0]    rd_data_r;

  logic          busy_r, busy_nxt;
  logic          error_r, error_nxt;
  logic [CW-1:0] load_pos_r, load_pos_nxt;
  logic [CW-1:0] send_pos_r, send_pos_nxt;
  logic [CW-1:0] writes_left_r, writes_left_nxt;
  logic [15:0]   reads_left_r, reads_left_nxt;
  logic [7:0]    restart_r, restart_nxt;
  logic          load_we;
  logic [WW-1:0] wc_ext;

  // Decide the command and next state for the item at hand
  always_comb begin
    busy_nxt        = busy_r;
    error_nxt       = error_r;
    load_pos_nxt    = load_pos_r;
    send_pos_nxt    = send_pos_r;
    writes_left_nxt = writes_left_r;
    reads_left_nxt  = reads_left_r;
    restart_nxt     = restart_r;
    load_we         = 1'b0;
    wc_ext          = WW'(item.write_count);
    result          = '0;
    result.command  = i2cmws_pkg::CMD_NONE;

    case (item.kind)
      i2cmws_pkg::KIND_LOAD: begin
        if (!busy_r && (load_pos_r < CW'(WRITE_DEPTH))) begin
          load_we      = 1'b1;
          load_pos_nxt = load_pos_r + 1'b1;
        end
      end
      i2cmws_pkg::KIND_START: begin
        if (!busy_r) begin
          // saturate the write count to the buffer depth
          if (wc_ext > WW'(WRITE_DEPTH)) begin
            writes_left_nxt = CW'(WRITE_DEPTH);
          end else begin
            writes_left_nxt = CW'(wc_ext);
          end
          reads_left_nxt  = item.with_read ? item.read_count : 16'd0;
          restart_nxt     = item.with_read ? (item.slave_address | 8'd1) : 8'd0;
          send_pos_nxt    = '0;
          load_pos_nxt    = '0;
          error_nxt       = 1'b0;
          busy_nxt        = 1'b1;
          result.command  = i2cmws_pkg::CMD_START;
          result.bus_byte = item.slave_address;
        end
      end
      i2cmws_pkg::KIND_EVENT: begin
        if (busy_r) begin
          if (item.nack_received) begin
            error_nxt      = 1'b1;
            busy_nxt       = 1'b0;
            result.command = i2cmws_pkg::CMD_NACK_STOP;
          end else if (writes_left_r != '0) begin
            writes_left_nxt = writes_left_r - 1'b1;
            send_pos_nxt    = send_pos_r + 1'b1;
            result.command  = i2cmws_pkg::CMD_WRITE;
            result.bus_byte = rd_data_r;
          end else if (restart_r != 8'd0) begin
            restart_nxt     = 8'd0;
            result.command  = i2cmws_pkg::CMD_RESTART;
            result.bus_byte = restart_r;
          end else if (reads_left_r != 16'd0) begin
            reads_left_nxt    = reads_left_r - 16'd1;
            result.read_valid = 1'b1;
            result.read_byte  = item.data_byte;
            if (reads_left_r != 16'd1) begin
              result.command = i2cmws_pkg::CMD_ACK_RECV;
            end else begin
              result.command = i2cmws_pkg::CMD_NACK_STOP;
              busy_nxt       = 1'b0;
            end
          end else begin
            result.command = i2cmws_pkg::CMD_NACK_STOP;
            busy_nxt       = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    result.busy_res = busy_nxt;
    result.error    = error_nxt;
  end

  // Advance the transaction state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      error_r       <= 1'b0;
      load_pos_r    <= '0;
      send_pos_r    <= '0;
      writes_left_r <= '0;
      reads_left_r  <= '0;
      restart_r     <= '0;
    end else if (step_en) begin
      busy_r        <= busy_nxt;
      error_r       <= error_nxt;
      load_pos_r    <= load_pos_nxt;
      send_pos_r    <= send_pos_nxt;
      writes_left_r <= writes_left_nxt;
      reads_left_r  <= reads_left_nxt;
      restart_r     <= restart_nxt;
    end
  end

  // Write buffer: fill on load, prefetch the next byte to send on every item.
  // Loads happen only while idle and a start always re-reads entry zero,
  // so the prefetched byte is current whenever a write command uses it.
  always_ff @(posedge clk) begin
    if (step_en && load_we) begin
      wbuf[load_pos_r[AW-1:0]] <= item.data_byte;
    end
    if (step_en) begin
      rd_data_r <= wbuf[send_pos_nxt[AW-1:0]];
    end
  end

  `I2CMWS_ASSERT_IMP(a_err_not_busy, clk, rst_n, error_r, !busy_r,
                     "error flag set while a transaction is in progress")
  `I2CMWS_ASSERT_IMP(a_writes_bound, clk, rst_n, 1'b1, writes_left_r <= CW'(WRITE_DEPTH),
                     "write count exceeds buffer depth")
  `I2CMWS_ASSERT_IMP(a_restart_rd, clk, rst_n, restart_r != 8'd0, restart_r[0],
                     "repeated start address lacks the read bit")
  `I2CMWS_ASSERT_NXT(a_send_step, clk, rst_n,
                     step_en && result.command == i2cmws_pkg::CMD_WRITE,
                     send_pos_r == $past(send_pos_r) + 1'b1,
                     "send position did not advance after a write byte")

endmodule

// File: rtl/i2c_master_write_read_sequencer_unit.sv
// ---------------------------------------------------------------------------
// I2C master write/read sequencer
// Sequences one combined write / repeated-start read transaction on I2C.
// ---------------------------------------------------------------------------
// Usage:
//   in_item carries load, start and bus event items over in_valid/in_ready.
//   Loads fill the write buffer while idle; a start issues the address and
//   arms the transaction; each bus event from the byte engine returns the
//   next command (write byte, repeated start, ack/nack receive or stop).
//   Every accepted item yields exactly one out_item on out_valid/out_ready.
// Timing:
//   An item is held in the input register, then its decision lands in the
//   output register, where the result is offered. One item per cycle is
//   sustained while out_ready stays high; the decision core's state update
//   sets that rate.
// Reset (rst_n low, synchronous) empties both registers and returns the
//   sequencer to idle with no error and an empty write buffer count.
// Stall: while out_ready is low the result holds; one more item is taken
//   into the input register, then in_ready drops until the result leaves.
// ---------------------------------------------------------------------------
`include "i2c_master_write_read_sequencer_unit_macros.svh"

module i2c_master_write_read_sequencer_unit #(
  parameter int WRITE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmws_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmws_pkg::out_item_t out_item
);

  i2cmws_pkg::in_item_t  s1_r;
  logic                  s1_valid_r;
  i2cmws_pkg::out_item_t res;
  i2cmws_pkg::out_item_t out_r;
  logic                  out_valid_r;
  logic                  step_en;
  logic                  in_fire;

  // Move an item forward whenever the output register is free or emptying
  assign step_en  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step_en;
  assign in_fire  = in_valid && in_ready;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_item;
    end
  end

  i2cmws_seq #(
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_r),
    .result  (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `I2CMWS_ASSERT_IMP(a_start_busy, clk, rst_n,
                     out_valid_r && out_r.command == i2cmws_pkg::CMD_START,
                     out_r.busy_res && !out_r.error,
                     "start result does not report a fresh busy transaction")
  `I2CMWS_ASSERT_IMP(a_read_cmd, clk, rst_n, out_valid_r && out_r.read_valid,
                     out_r.command == i2cmws_pkg::CMD_ACK_RECV ||
                     out_r.command == i2cmws_pkg::CMD_NACK_STOP,
                     "read byte returned with a non-receive command")
  `I2CMWS_ASSERT_IMP(a_stop_idle, clk, rst_n,
                     out_valid_r && out_r.command == i2cmws_pkg::CMD_NACK_STOP,
                     !out_r.busy_res,
                     "stop result still reports busy")

endmodule
